// ----- sv/aoc_pkg.sv -----
// shared constants, types and the rounded divide by 255 for the alpha-over compositor
package aoc_pkg;

    localparam int CHAN_W        = 8;
    localparam int CHANNELS      = 3;
    localparam int CHAN_MAX      = 255;
    localparam int HALF_DIV      = 127;
    localparam int PROD_W        = 2 * CHAN_W;
    localparam int TRIPLE_W      = 3 * CHAN_W;
    localparam int QUOT255_W     = TRIPLE_W - CHAN_W + 2;
    localparam int NUM_W         = PROD_W + 2;
    localparam int QUO_W         = CHAN_W;
    localparam int BITS_PER_STEP = 2;
    localparam int DIV_STAGES    = QUO_W / BITS_PER_STEP;

    typedef struct packed {
        logic [CHANNELS-1:0][CHAN_W-1:0] colour;
        logic [CHAN_W-1:0]               alpha;
    } aoc_pixel_t;

    typedef struct packed {
        logic                           valid;
        logic [CHAN_W-1:0]              alpha;
        logic [CHANNELS-1:0][NUM_W-1:0] num;
    } aoc_front_t;

    // (x + 127) / 255 by reciprocal estimate and a small correction
    function automatic logic [QUOT255_W-1:0] div255_round(input logic [TRIPLE_W-1:0] x);
        logic [TRIPLE_W:0]    y;
        logic [TRIPLE_W+1:0]  sum;
        logic [TRIPLE_W+1:0]  back;
        logic [TRIPLE_W+1:0]  r;
        logic [QUOT255_W-1:0] q;
        y    = {1'b0, x} + (TRIPLE_W+1)'(HALF_DIV);
        sum  = {1'b0, y} + (TRIPLE_W+2)'(y >> CHAN_W) + (TRIPLE_W+2)'(y >> (2 * CHAN_W));
        q    = QUOT255_W'(sum >> CHAN_W);
        back = ((TRIPLE_W+2)'(q) << CHAN_W) - (TRIPLE_W+2)'(q);
        r    = {1'b0, y} - back;
        if (r >= (TRIPLE_W+2)'(2 * CHAN_MAX))
        begin
            q = q + QUOT255_W'(2);
        end
        else if (r >= (TRIPLE_W+2)'(CHAN_MAX))
        begin
            q = q + QUOT255_W'(1);
        end
        return q;
    endfunction

endpackage

// ----- sv/alpha_over_composite.sv -----
// top level of the straight-alpha source-over compositor for rgba8 pixel pairs
// One pixel pair is taken on every clock where start is high; busy never rises, so the
// block runs at one transfer per cycle. Each result appears on the out_ ports with done
// high for one cycle; the receiver cannot stall the block and must take every result in
// that cycle. A pair passes through three stages of multiply and divide-by-255 work,
// four stages of a two-bit-per-stage divider for the colour quotient and one output
// register. Colour results saturate at 255 and are zero when the composite alpha is
// zero.
module alpha_over_composite import aoc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CHAN_W-1:0] src_red,
    input  logic [CHAN_W-1:0] src_green,
    input  logic [CHAN_W-1:0] src_blue,
    input  logic [CHAN_W-1:0] src_alpha,
    input  logic [CHAN_W-1:0] dst_red,
    input  logic [CHAN_W-1:0] dst_green,
    input  logic [CHAN_W-1:0] dst_blue,
    input  logic [CHAN_W-1:0] dst_alpha,
    output logic              done,
    output logic [CHAN_W-1:0] out_red,
    output logic [CHAN_W-1:0] out_green,
    output logic [CHAN_W-1:0] out_blue,
    output logic [CHAN_W-1:0] out_alpha
);

    aoc_pixel_t                      src, dst;
    aoc_front_t                      front;
    logic [CHANNELS-1:0][CHAN_W-1:0] quo;
    logic                            valid_reg [DIV_STAGES];
    logic [CHAN_W-1:0]               alpha_reg [DIV_STAGES];
    logic                            done_reg;
    logic [CHANNELS-1:0][CHAN_W-1:0] colour_reg, colour_next;
    logic [CHAN_W-1:0]               out_alpha_reg;

    assign busy       = 1'b0;
    assign src.colour = {src_blue, src_green, src_red};
    assign src.alpha  = src_alpha;
    assign dst.colour = {dst_blue, dst_green, dst_red};
    assign dst.alpha  = dst_alpha;

    aoc_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start && !busy),
        .src   (src),
        .dst   (dst),
        .front (front)
    );

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_div
        aoc_div u_div
        (
            .clk      (clk),
            .num      (front.num[c]),
            .divisor  (front.alpha),
            .quotient (quo[c])
        );
    end

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (alpha_reg[DIV_STAGES-1] == '0)
            begin
                colour_next[c] = '0;
            end
            else
            begin
                colour_next[c] = quo[c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= front.valid;
            for (int s = 1; s < DIV_STAGES; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
            done_reg <= valid_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        alpha_reg[0] <= front.alpha;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            alpha_reg[s] <= alpha_reg[s-1];
        end
        colour_reg    <= colour_next;
        out_alpha_reg <= alpha_reg[DIV_STAGES-1];
    end

    assign done      = done_reg;
    assign out_red   = colour_reg[0];
    assign out_green = colour_reg[1];
    assign out_blue  = colour_reg[2];
    assign out_alpha = out_alpha_reg;

endmodule

// ----- sv/aoc_front.sv -----
// front pipeline: inverse alpha products, output alpha and the colour numerators
module aoc_front import aoc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  aoc_pixel_t src,
    input  aoc_pixel_t dst,
    output aoc_front_t front
);

    logic                            v1_reg, v2_reg, v3_reg;
    logic [PROD_W-1:0]               ainv1_reg, ainv1_next;
    aoc_pixel_t                      src1_reg, dst1_reg;
    logic [CHAN_W-1:0]               oa2_reg, oa2_next;
    logic [CHANNELS-1:0][PROD_W-1:0] scsa2_reg, scsa2_next;
    logic [CHANNELS-1:0][TRIPLE_W-1:0] tri2_reg, tri2_next;
    logic [CHAN_W-1:0]               oa3_reg;
    logic [CHANNELS-1:0][NUM_W-1:0]  num3_reg, num3_next;
    logic [CHAN_W:0]                 oa_sum;
    logic [CHAN_W-1:0]               inv;

    always_comb
    begin
        inv        = CHAN_W'(CHAN_MAX) - src.alpha;
        ainv1_next = PROD_W'(dst.alpha) * PROD_W'(inv);
    end

    always_comb
    begin
        oa_sum = {1'b0, src1_reg.alpha}
               + (CHAN_W+1)'(div255_round(TRIPLE_W'(ainv1_reg)));
        if (oa_sum > (CHAN_W+1)'(CHAN_MAX))
        begin
            oa2_next = CHAN_W'(CHAN_MAX);
        end
        else
        begin
            oa2_next = oa_sum[CHAN_W-1:0];
        end
        for (int c = 0; c < CHANNELS; c++)
        begin
            scsa2_next[c] = PROD_W'(src1_reg.colour[c]) * PROD_W'(src1_reg.alpha);
            tri2_next[c]  = TRIPLE_W'(dst1_reg.colour[c]) * TRIPLE_W'(ainv1_reg);
        end
    end

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            num3_next[c] = NUM_W'(scsa2_reg[c]) + NUM_W'(div255_round(tri2_reg[c]))
                         + NUM_W'(oa2_reg >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ainv1_reg <= ainv1_next;
        src1_reg  <= src;
        dst1_reg  <= dst;
        oa2_reg   <= oa2_next;
        scsa2_reg <= scsa2_next;
        tri2_reg  <= tri2_next;
        oa3_reg   <= oa2_reg;
        num3_reg  <= num3_next;
    end

    assign front.valid = v3_reg;
    assign front.alpha = oa3_reg;
    assign front.num   = num3_reg;

endmodule

// ----- sv/aoc_div.sv -----
// pipelined restoring divider, two quotient bits a stage, saturating at full scale
module aoc_div import aoc_pkg::*;
(
    input  logic              clk,
    input  logic [NUM_W-1:0]  num,
    input  logic [CHAN_W-1:0] divisor,
    output logic [CHAN_W-1:0] quotient
);

    logic [NUM_W-1:0]  rem_reg  [DIV_STAGES-1];
    logic [NUM_W-1:0]  rem_next [DIV_STAGES-1];
    logic [CHAN_W-1:0] dvs_reg  [DIV_STAGES-1];
    logic [CHAN_W-1:0] dvs_next [DIV_STAGES-1];
    logic [QUO_W-1:0]  quo_reg  [DIV_STAGES];
    logic [QUO_W-1:0]  quo_next [DIV_STAGES];
    logic              sat_reg  [DIV_STAGES];
    logic              sat_next [DIV_STAGES];

    always_comb
    begin
        logic [NUM_W-1:0]  r;
        logic [NUM_W-1:0]  dsh;
        logic [QUO_W-1:0]  q;
        logic [CHAN_W-1:0] d;
        logic              st;
        int                k;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                r  = num;
                d  = divisor;
                q  = '0;
                st = num >= (NUM_W'(divisor) << QUO_W);
            end
            else
            begin
                r  = rem_reg[s-1];
                d  = dvs_reg[s-1];
                q  = quo_reg[s-1];
                st = sat_reg[s-1];
            end
            for (int j = 0; j < BITS_PER_STEP; j++)
            begin
                k   = QUO_W - 1 - s * BITS_PER_STEP - j;
                dsh = NUM_W'(d) << k;
                if (r >= dsh)
                begin
                    r    = r - dsh;
                    q[k] = 1'b1;
                end
            end
            if (s < DIV_STAGES - 1)
            begin
                rem_next[s] = r;
                dvs_next[s] = d;
            end
            quo_next[s] = q;
            sat_next[s] = st;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
        sat_reg <= sat_next;
    end

    assign quotient = sat_reg[DIV_STAGES-1] ? CHAN_W'(CHAN_MAX) : quo_reg[DIV_STAGES-1];

endmodule

// ----- tb/alpha_over_composite_test.sv -----
// testbench for the straight-alpha source-over compositor with its own pixel predictor
module alpha_over_composite_test import aoc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF    = 2;
    localparam int LATENCY     = 8;
    localparam int CYCLE_LIMIT = 40000;
    localparam int RANDOM_RUN  = 240;

    typedef struct {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } composite_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [CHAN_W-1:0] src_red = '0;
    logic [CHAN_W-1:0] src_green = '0;
    logic [CHAN_W-1:0] src_blue = '0;
    logic [CHAN_W-1:0] src_alpha = '0;
    logic [CHAN_W-1:0] dst_red = '0;
    logic [CHAN_W-1:0] dst_green = '0;
    logic [CHAN_W-1:0] dst_blue = '0;
    logic [CHAN_W-1:0] dst_alpha = '0;
    logic              done;
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_alpha;

    composite_t pending_pixels[$];
    int         error_count = 0;
    int         cycle_count = 0;
    bit         gaps_on = 1'b1;

    alpha_over_composite u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .src_red   (src_red),
        .src_green (src_green),
        .src_blue  (src_blue),
        .src_alpha (src_alpha),
        .dst_red   (dst_red),
        .dst_green (dst_green),
        .dst_blue  (dst_blue),
        .dst_alpha (dst_alpha),
        .done      (done),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_alpha (out_alpha)
    );

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    function automatic int unsigned rounded_255th(input int unsigned x);
        return (x + 127) / 255;
    endfunction

    function automatic logic [CHAN_W-1:0] mix_colour(input int unsigned sc, input int unsigned sa,
                                                     input int unsigned dc, input int unsigned da,
                                                     input int unsigned oa);
        int unsigned weighted;
        int unsigned quot;
        if (oa == 0)
        begin
            return '0;
        end
        weighted = sc * sa + rounded_255th(dc * da * (255 - sa));
        quot     = (weighted + oa / 2) / oa;
        return (quot > 255) ? CHAN_W'(255) : CHAN_W'(quot);
    endfunction

    function automatic composite_t predict_composite(
        input logic [CHAN_W-1:0] sr, input logic [CHAN_W-1:0] sg,
        input logic [CHAN_W-1:0] sb, input logic [CHAN_W-1:0] sa,
        input logic [CHAN_W-1:0] dr, input logic [CHAN_W-1:0] dg,
        input logic [CHAN_W-1:0] db, input logic [CHAN_W-1:0] da);
        composite_t  px;
        int unsigned oa;
        oa = int'(sa) + rounded_255th(int'(da) * (255 - int'(sa)));
        if (oa > 255)
        begin
            oa = 255;
        end
        px.red   = mix_colour(sr, sa, dr, da, oa);
        px.green = mix_colour(sg, sa, dg, da, oa);
        px.blue  = mix_colour(sb, sa, db, da, oa);
        px.alpha = CHAN_W'(oa);
        return px;
    endfunction

    task automatic compare_channel(input string name, input logic [CHAN_W-1:0] want,
                                   input logic [CHAN_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // result check at every rising edge
    always @(posedge clk)
    begin
        composite_t want;
        if (rst_n && done)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("result transfer with no pixel pair outstanding");
                error_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                compare_channel("out_red", want.red, out_red);
                compare_channel("out_green", want.green, out_green);
                compare_channel("out_blue", want.blue, out_blue);
                compare_channel("out_alpha", want.alpha, out_alpha);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_pixels(input logic [CHAN_W-1:0] sr, input logic [CHAN_W-1:0] sg,
                               input logic [CHAN_W-1:0] sb, input logic [CHAN_W-1:0] sa,
                               input logic [CHAN_W-1:0] dr, input logic [CHAN_W-1:0] dg,
                               input logic [CHAN_W-1:0] db, input logic [CHAN_W-1:0] da);
        int gap;
        gap = (gaps_on && $urandom_range(99) < 25) ? $urandom_range(1, 2) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start     <= 1'b1;
        src_red   <= sr;
        src_green <= sg;
        src_blue  <= sb;
        src_alpha <= sa;
        dst_red   <= dr;
        dst_green <= dg;
        dst_blue  <= db;
        dst_alpha <= da;
        do
            @(posedge clk);
        while (busy);
        pending_pixels.push_back(predict_composite(sr, sg, sb, sa, dr, dg, db, da));
    endtask

    // alphas lean towards the ends of the range, where the rounding is sharpest
    function automatic logic [CHAN_W-1:0] pick_alpha();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return CHAN_W'($urandom_range(1, 4));
            3: return CHAN_W'($urandom_range(250, 254));
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    task automatic test_directed_corners();
        send_pixels(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_pixels(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        send_pixels(8'd12, 8'd34, 8'd56, 8'd255, 8'd200, 8'd100, 8'd50, 8'd0);
        send_pixels(8'd12, 8'd34, 8'd56, 8'd255, 8'd200, 8'd100, 8'd50, 8'd255);
        send_pixels(8'd12, 8'd34, 8'd56, 8'd0, 8'd200, 8'd100, 8'd50, 8'd255);
        // zero composite alpha with non-zero colours
        send_pixels(8'd255, 8'd128, 8'd1, 8'd0, 8'd255, 8'd127, 8'd2, 8'd0);
        // rounding pushes the colour quotient past 255
        send_pixels(8'd255, 8'd255, 8'd255, 8'd100, 8'd255, 8'd255, 8'd255, 8'd2);
        send_pixels(8'd0, 8'd0, 8'd0, 8'd100, 8'd0, 8'd0, 8'd0, 8'd2);
        send_pixels(8'd255, 8'd0, 8'd255, 8'd1, 8'd0, 8'd255, 8'd0, 8'd0);
        send_pixels(8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd1);
        send_pixels(8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55);
        send_pixels(8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA);
        send_pixels(8'd200, 8'd17, 8'd99, 8'd128, 8'd3, 8'd240, 8'd128, 8'd128);
        send_pixels(8'd1, 8'd254, 8'd127, 8'd254, 8'd254, 8'd1, 8'd128, 8'd255);
        send_pixels(8'd255, 8'd255, 8'd255, 8'd1, 8'd0, 8'd0, 8'd0, 8'd255);
        send_pixels(8'd0, 8'd0, 8'd0, 8'd1, 8'd255, 8'd255, 8'd255, 8'd255);
    endtask

    task automatic test_random_pixels(input int count);
        repeat (count)
        begin
            send_pixels(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom), pick_alpha(),
                        CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom), pick_alpha());
        end
    endtask

    task automatic test_back_to_back_stream(input int count);
        gaps_on = 1'b0;
        test_random_pixels(count);
        gaps_on = 1'b1;
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        test_directed_corners();
        test_random_pixels(RANDOM_RUN);
        test_back_to_back_stream(RANDOM_RUN);
        test_random_pixels(20);
        @(negedge clk);
        start <= 1'b0;
        while (pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 4) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
